[rtl/core/ddo_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table of the odometry core.
package ddo_pkg;

    localparam int IN_W     = 24;   // wheel distance word
    localparam int SUM_W    = 25;   // sum and difference of the wheels
    localparam int POS_W    = 32;   // Q16.16 position
    localparam int ANG_W    = 32;   // binary angle
    localparam int GAIN_W   = 32;
    localparam int CX_W     = 34;   // CORDIC x and y
    localparam int CZ_W     = 33;   // CORDIC residual angle
    localparam int PROD_W   = SUM_W + CX_W;
    localparam int DX_W     = PROD_W - 31;
    localparam int ATAN_IDX_W = 5;

    localparam int CORDIC_STEPS_DEFAULT = 24;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd1205583000;
    localparam logic [CX_W-1:0]   CORDIC_X0  = 34'd652032874;
    localparam logic [ANG_W-1:0]  QUARTER_TURN = 32'h4000_0000;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'h4000_0000);

    // APB register map
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_HEADING_GAIN = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HMUL,
        S_INIT,
        S_ITER,
        S_FLIP,
        S_MULX,
        S_ADDX,
        S_ADDY,
        S_DONE
    } t_state;

    // Arctangent of 2^-i in binary-angle units (2^32 per turn).
    function automatic logic [ANG_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANG_W-1:0] v;
        unique case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            5'd24: v = 32'h0000_0029;
            5'd25: v = 32'h0000_0014;
            5'd26: v = 32'h0000_000A;
            5'd27: v = 32'h0000_0005;
            5'd28: v = 32'h0000_0003;
            5'd29: v = 32'h0000_0001;
            5'd30: v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/ddo_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for wheel distance words and pose words.
interface ddo_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ddo_pkg::IN_W-1:0]     left_distance;
    logic signed [ddo_pkg::IN_W-1:0]     right_distance;

    modport source (output valid, output left_distance, output right_distance, input ready);
    modport sink   (input valid, input left_distance, input right_distance, output ready);
endinterface

interface ddo_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ddo_pkg::POS_W-1:0]    pos_x;
    logic signed [ddo_pkg::POS_W-1:0]    pos_y;
    logic        [ddo_pkg::ANG_W-1:0]    heading;

    modport source (output valid, output pos_x, output pos_y, output heading, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

[rtl/core/differential_drive_odometry_core.sv]
`timescale 1ns / 1ps
// An accepted word passes the heading multiply, CORDIC setup, CORDIC steps, sign flip,
// x product and the two position updates; the next word is taken only after its pose word
// is loaded, as the single CORDIC rotation stage is used once per step.
// One shared multiplier forms the heading product and both position products.
// Reset (synchronous, active low) clears the pose to zero and loads the default gain.
module differential_drive_odometry_core #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ddo_in_if.sink                        i_in,
    ddo_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ddo_pkg::PADDR_W-1:0]   paddr,
    input  logic [ddo_pkg::PDATA_W-1:0]   pwdata,
    output logic [ddo_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

    ddo_pkg::t_state r_state, n_state;

    logic [ddo_pkg::GAIN_W-1:0]        r_gain;
    logic signed [ddo_pkg::POS_W-1:0]  r_pose_x, r_pose_y;
    logic [ddo_pkg::ANG_W-1:0]         r_heading;
    logic [CNT_W-1:0]                  r_cnt;
    logic                              r_out_valid;

    logic signed [ddo_pkg::SUM_W-1:0]  r_diff, r_sum;
    logic signed [ddo_pkg::PROD_W-1:0] r_prod;
    logic [ddo_pkg::ANG_W-1:0]         r_delta;
    logic                              r_flip;
    logic signed [ddo_pkg::CX_W-1:0]   r_x, r_y;
    logic signed [ddo_pkg::CZ_W-1:0]   r_z;
    logic signed [ddo_pkg::POS_W-1:0]  r_out_x, r_out_y;
    logic [ddo_pkg::ANG_W-1:0]         r_out_heading;

    // control decoded from the state
    logic c_in_ready;
    logic c_out_load;
    logic c_mul_en;

    logic cfg_wr;
    logic in_acc;

    logic signed [ddo_pkg::SUM_W-1:0]  mul_a;
    logic signed [ddo_pkg::CX_W-1:0]   mul_b;
    logic signed [ddo_pkg::PROD_W-1:0] mul_p;

    logic [ddo_pkg::ANG_W-1:0]         mid;
    logic [ddo_pkg::ANG_W-1:0]         mid_q;
    logic                              mid_flip;
    logic [ddo_pkg::ANG_W-1:0]         mid_fold;

    logic signed [ddo_pkg::CX_W-1:0]   xs, ys;
    logic signed [ddo_pkg::CZ_W-1:0]   at;

    logic signed [ddo_pkg::PROD_W-1:0] prod_rnd;
    logic signed [ddo_pkg::DX_W-1:0]   dpos;
    logic signed [ddo_pkg::POS_W-1:0]  sat_x, sat_y;

    // Adds a position step to a coordinate and clamps to the signed range.
    function automatic logic signed [ddo_pkg::POS_W-1:0] sat_add(
        input logic signed [ddo_pkg::POS_W-1:0] p,
        input logic signed [ddo_pkg::DX_W-1:0]  d
    );
        logic signed [ddo_pkg::POS_W:0] s;
        s = {p[ddo_pkg::POS_W-1], p}
            + {{(ddo_pkg::POS_W + 1 - ddo_pkg::DX_W){d[ddo_pkg::DX_W-1]}}, d};
        if (s[ddo_pkg::POS_W] != s[ddo_pkg::POS_W-1]) begin
            sat_add = s[ddo_pkg::POS_W] ? {1'b1, {(ddo_pkg::POS_W-1){1'b0}}}
                                        : {1'b0, {(ddo_pkg::POS_W-1){1'b1}}};
        end else begin
            sat_add = s[ddo_pkg::POS_W-1:0];
        end
    endfunction

    assign cfg_wr = psel && penable && pwrite && pready;
    assign in_acc = i_in.valid && c_in_ready;

    assign pready      = 1'b1;
    assign i_in.ready  = c_in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.pos_x   = r_out_x;
    assign o_out.pos_y   = r_out_y;
    assign o_out.heading = r_out_heading;

    always_comb begin
        unique case (paddr[2])
            ddo_pkg::REG_HEADING_GAIN: prdata = r_gain;
            default:                   prdata = '0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ddo_pkg::S_IDLE: if (i_in.valid) n_state = ddo_pkg::S_HMUL;
            ddo_pkg::S_HMUL: n_state = ddo_pkg::S_INIT;
            ddo_pkg::S_INIT: n_state = ddo_pkg::S_ITER;
            ddo_pkg::S_ITER: if (r_cnt == CNT_LAST) n_state = ddo_pkg::S_FLIP;
            ddo_pkg::S_FLIP: n_state = ddo_pkg::S_MULX;
            ddo_pkg::S_MULX: n_state = ddo_pkg::S_ADDX;
            ddo_pkg::S_ADDX: n_state = ddo_pkg::S_ADDY;
            ddo_pkg::S_ADDY: n_state = ddo_pkg::S_DONE;
            ddo_pkg::S_DONE: if (!r_out_valid || o_out.ready) n_state = ddo_pkg::S_IDLE;
            default:         n_state = ddo_pkg::S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        c_in_ready = 1'b0;
        c_out_load = 1'b0;
        c_mul_en   = 1'b0;
        unique case (r_state)
            ddo_pkg::S_IDLE: c_in_ready = 1'b1;
            ddo_pkg::S_HMUL,
            ddo_pkg::S_MULX,
            ddo_pkg::S_ADDX: c_mul_en = 1'b1;
            ddo_pkg::S_DONE: c_out_load = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    // Shared multiplier: heading product first, then sum times cos and sum times sin.
    always_comb begin
        if (r_state == ddo_pkg::S_HMUL) begin
            mul_a = r_diff;
            mul_b = $signed({2'b00, r_gain});
        end else if (r_state == ddo_pkg::S_MULX) begin
            mul_a = r_sum;
            mul_b = r_x;
        end else begin
            mul_a = r_sum;
            mul_b = r_y;
        end
        mul_p = mul_a * mul_b;
    end

    // Midpoint heading, folded into the quarter turns around zero.
    always_comb begin
        mid      = r_heading + r_prod[48:17];
        mid_q    = mid + ddo_pkg::QUARTER_TURN;
        mid_flip = mid_q[ddo_pkg::ANG_W-1];
        mid_fold = {mid[ddo_pkg::ANG_W-1] ^ mid_flip, mid[ddo_pkg::ANG_W-2:0]};
    end

    always_comb begin
        xs = r_x >>> r_cnt;
        ys = r_y >>> r_cnt;
        at = $signed({1'b0, ddo_pkg::atan_entry(ddo_pkg::ATAN_IDX_W'(r_cnt))});
    end

    always_comb begin
        prod_rnd = r_prod + ddo_pkg::ROUND_HALF;
        dpos     = prod_rnd[ddo_pkg::PROD_W-1:31];
        sat_x    = sat_add(r_pose_x, dpos);
        sat_y    = sat_add(r_pose_y, dpos);
    end

    // Control and pose state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ddo_pkg::S_IDLE;
            r_gain      <= ddo_pkg::GAIN_RESET;
            r_pose_x    <= '0;
            r_pose_y    <= '0;
            r_heading   <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr && paddr[2] == ddo_pkg::REG_HEADING_GAIN) begin
                r_gain <= pwdata;
            end
            if (r_state == ddo_pkg::S_INIT) begin
                r_cnt <= '0;
            end else if (r_state == ddo_pkg::S_ITER && r_cnt != CNT_LAST) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == ddo_pkg::S_ADDX) begin
                r_pose_x <= sat_x;
            end
            if (r_state == ddo_pkg::S_ADDY) begin
                r_pose_y  <= sat_y;
                r_heading <= r_heading + r_delta;
            end
            if (c_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_diff <= {i_in.right_distance[ddo_pkg::IN_W-1], i_in.right_distance}
                    - {i_in.left_distance[ddo_pkg::IN_W-1], i_in.left_distance};
            r_sum  <= {i_in.right_distance[ddo_pkg::IN_W-1], i_in.right_distance}
                    + {i_in.left_distance[ddo_pkg::IN_W-1], i_in.left_distance};
        end
        if (c_mul_en) begin
            r_prod <= mul_p;
        end
        unique case (r_state)
            ddo_pkg::S_INIT: begin
                r_delta <= r_prod[47:16];
                r_flip  <= mid_flip;
                r_x     <= $signed(ddo_pkg::CORDIC_X0);
                r_y     <= '0;
                r_z     <= {mid_fold[ddo_pkg::ANG_W-1], mid_fold};
            end
            ddo_pkg::S_ITER: begin
                if (!r_z[ddo_pkg::CZ_W-1]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
            end
            ddo_pkg::S_FLIP: begin
                // The fold added half a turn, so cos and sin change sign.
                if (r_flip) begin
                    r_x <= -r_x;
                    r_y <= -r_y;
                end
            end
            default: ;
        endcase
        if (c_out_load) begin
            r_out_x       <= r_pose_x;
            r_out_y       <= r_pose_y;
            r_out_heading <= r_heading;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == ddo_pkg::S_HMUL)
        else $error("accepted word did not start the heading multiply");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LAST)
        else $error("CORDIC step counter ran past the last step");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ddo_pkg::S_DONE))
        else $error("pose word raised outside the done state");

    a_z_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ddo_pkg::S_ITER |-> r_z[ddo_pkg::CZ_W-1] == r_z[ddo_pkg::CZ_W-2])
        else $error("CORDIC residual angle left its range");

endmodule

[verif/ddo_pose_checker.sv]
`timescale 1ns / 1ps
// Pose predictor and scoreboard that watches the channels and register port of the odometry core.
module ddo_pose_checker #(
    parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ddo_in_if                             i_in_mon,
    ddo_out_if                            i_out_mon,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [ddo_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [ddo_pkg::PDATA_W-1:0]   i_pwdata,
    input  logic [ddo_pkg::PDATA_W-1:0]   i_prdata,
    input  logic                          i_pready,
    output int                            o_pending,
    output int                            o_fail_count
);
    import ddo_pkg::*;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic        [ANG_W-1:0] heading;
    } t_pose;

    localparam logic [PADDR_W-1:0] GAIN_ADDR = PADDR_W'(4 * int'(REG_HEADING_GAIN));
    localparam longint UNIT_GAIN_Q30 = 64'sd652032874;
    localparam longint HALF_LSB_Q31  = 64'sd1073741824;
    localparam longint POS_MAX       = 64'sd2147483647;
    localparam longint POS_MIN       = -64'sd2147483648;

    // Arctangent of 2^-i, one turn = 2^32.
    localparam logic [0:31][31:0] ARCTAN_STEP = {
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    t_pose             pose_now;
    logic [GAIN_W-1:0] gain_now;
    t_pose             pose_queue[$];
    int                fault_total = 0;

    assign o_fail_count = fault_total;

    function automatic longint clamp_pos(input longint v);
        if (v > POS_MAX) begin
            return POS_MAX;
        end
        if (v < POS_MIN) begin
            return POS_MIN;
        end
        return v;
    endfunction

    // Cosine and sine in Q2.30. Angles outside the right half plane are turned
    // by half a turn first and the result negated afterwards.
    function automatic void rotate_unit(input logic [ANG_W-1:0] ang,
                                        output longint c, output longint s);
        logic             flip;
        logic [ANG_W-1:0] a;
        logic [ANG_W-1:0] ang_q;
        longint           z;
        longint           x;
        longint           y;
        longint           xs;
        longint           ys;
        ang_q = ang + QUARTER_TURN;
        flip  = ang_q[ANG_W-1];
        a     = flip ? ang - 32'h8000_0000 : ang;
        z     = longint'($signed(a));
        x     = UNIT_GAIN_Q30;
        y     = 0;
        for (int i = 0; i < STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ARCTAN_STEP[i]);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ARCTAN_STEP[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic t_pose advance_pose(input t_pose p, input logic [GAIN_W-1:0] g,
                                           input logic signed [IN_W-1:0] l,
                                           input logic signed [IN_W-1:0] r);
        longint     lw;
        longint     rw;
        longint     diff;
        longint     sum;
        longint     c;
        longint     s;
        longint     dx;
        longint     dy;
        logic [63:0] prod;
        logic [ANG_W-1:0] mid;
        t_pose      n;
        lw   = l;
        rw   = r;
        diff = rw - lw;
        sum  = rw + lw;
        // The product wraps at 64 bits; the heading change sits in bits 47..16.
        prod = $unsigned(diff) * {32'd0, g};
        mid  = p.heading + prod[48:17];
        rotate_unit(mid, c, s);
        dx = (sum * c + HALF_LSB_Q31) >>> 31;
        dy = (sum * s + HALF_LSB_Q31) >>> 31;
        n.x       = POS_W'(clamp_pos(longint'($signed(p.x)) + dx));
        n.y       = POS_W'(clamp_pos(longint'($signed(p.y)) + dy));
        n.heading = p.heading + prod[47:16];
        return n;
    endfunction

    always @(posedge i_clk) begin
        t_pose want;
        if (!i_rst_n) begin
            pose_now = '0;
            gain_now = GAIN_RESET;
            pose_queue.delete();
            o_pending <= 0;
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == GAIN_ADDR) begin
                if (i_pwrite) begin
                    gain_now = i_pwdata;
                end else if (i_prdata !== gain_now) begin
                    $error("heading_gain: expected %h, got %h", gain_now, i_prdata);
                    fault_total++;
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (pose_queue.size() == 0) begin
                    $error("pose word with no expectation waiting");
                    fault_total++;
                end else begin
                    want = pose_queue.pop_front();
                    if (i_out_mon.pos_x !== want.x) begin
                        $error("pos_x: expected %0d, got %0d", want.x, i_out_mon.pos_x);
                        fault_total++;
                    end
                    if (i_out_mon.pos_y !== want.y) begin
                        $error("pos_y: expected %0d, got %0d", want.y, i_out_mon.pos_y);
                        fault_total++;
                    end
                    if (i_out_mon.heading !== want.heading) begin
                        $error("heading: expected %h, got %h", want.heading,
                               i_out_mon.heading);
                        fault_total++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                pose_now = advance_pose(pose_now, gain_now, i_in_mon.left_distance,
                                        i_in_mon.right_distance);
                pose_queue = {pose_queue, pose_now};
            end
            o_pending <= pose_queue.size();
        end
    end

endmodule

[verif/differential_drive_odometry_core_test.sv]
`timescale 1ns / 1ps
// Stimulus, clocking and verdict for the differential drive odometry core.
module differential_drive_odometry_core_test;
    import ddo_pkg::*;

    localparam int STEPS       = CORDIC_STEPS_DEFAULT;
    localparam int SETTLE      = STEPS + 8;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam logic [PADDR_W-1:0] GAIN_ADDR = PADDR_W'(4 * int'(REG_HEADING_GAIN));
    localparam logic signed [IN_W-1:0] DIST_MAX = 24'sh7F_FFFF;
    localparam logic signed [IN_W-1:0] DIST_MIN = 24'sh80_0000;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    int                  pending;
    int                  fail_count;
    int                  idle_pct = 30;
    int                  quiet_cycles = 0;
    bit                  hold_req;

    ddo_in_if  in_ch();
    ddo_out_if out_ch();

    always #10 i_clk = ~i_clk;

    differential_drive_odometry_core #(.CORDIC_STEPS(STEPS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ddo_pose_checker #(.STEPS(STEPS)) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Offers one distance word and waits for it to be taken, then maybe idles.
    task automatic send_word(input logic signed [IN_W-1:0] l, input logic signed [IN_W-1:0] r);
        in_ch.valid          <= 1'b1;
        in_ch.left_distance  <= l;
        in_ch.right_distance <= r;
        do @(posedge i_clk); while (!in_ch.ready);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int count);
        int base;
        logic signed [IN_W-1:0] l;
        logic signed [IN_W-1:0] r;
        logic signed [IN_W-1:0] corner [4] = '{DIST_MAX, DIST_MIN, 24'sd0, -24'sd1};
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    // Ordinary driving: similar wheel travel with some slip.
                    base = int'($urandom_range(0, 16383)) - 8192;
                    l = IN_W'(base + int'($urandom_range(0, 511)) - 256);
                    r = IN_W'(base + int'($urandom_range(0, 511)) - 256);
                end
                5, 6, 7: begin
                    l = IN_W'($urandom());
                    r = IN_W'($urandom());
                end
                8: begin
                    l = corner[$urandom_range(0, 3)];
                    r = corner[$urandom_range(0, 3)];
                end
                default: begin
                    base = int'($urandom_range(0, 8388607));
                    if ($urandom_range(0, 1) == 1) begin
                        base = -base;
                    end
                    l = IN_W'(base);
                    r = IN_W'(base - int'($urandom_range(0, 1023)));
                end
            endcase
            send_word(l, r);
        end
    endtask

    // Drains the core so a register may be written.
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes the gain and reads it back; the checker compares the read data.
    task automatic program_gain(input logic [GAIN_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GAIN_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: short random stalls, and one long hold-off when asked.
    initial begin
        bit hold_served;
        hold_served  = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                out_ch.ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 4) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        hold_req             <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.left_distance  <= '0;
        in_ch.right_distance <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset gain: standstill, wheel extremes, spins and straight runs.
        send_word(24'sd0, 24'sd0);
        send_word(DIST_MAX, DIST_MAX);
        send_word(DIST_MIN, DIST_MIN);
        send_word(DIST_MAX, DIST_MIN);
        send_word(DIST_MIN, DIST_MAX);
        send_word(24'sd1, -24'sd1);
        send_word(-24'sd1, 24'sd1);
        send_word(24'sd65536, 24'sd65536);
        send_word(24'sd0, DIST_MAX);
        send_word(DIST_MAX, 24'sd0);
        send_word(DIST_MIN, 24'sd0);
        send_word(24'sd0, DIST_MIN);
        send_word(24'sd12345, -24'sd54321);
        send_word(24'sd1, 24'sd1);

        // Largest gain: the heading wraps on almost every word.
        quiesce();
        program_gain(32'hFFFF_FFFF);
        send_word(DIST_MIN, DIST_MAX);
        send_word(DIST_MIN, DIST_MAX);
        send_word(DIST_MAX, DIST_MIN);
        send_word(DIST_MAX, DIST_MIN);
        send_random(300);

        // Zero gain: the heading is frozen, so long runs drive the position
        // into saturation on both sides.
        quiesce();
        program_gain(32'd0);
        idle_pct = 15;
        send_word(DIST_MAX, DIST_MIN);
        send_word(-24'sd100000, 24'sd100000);
        for (int n = 0; n < 360; n++) begin
            send_word(IN_W'(DIST_MAX - $urandom_range(0, 255)),
                      IN_W'(DIST_MAX - $urandom_range(0, 255)));
        end
        for (int n = 0; n < 570; n++) begin
            send_word(IN_W'(DIST_MIN + $urandom_range(0, 255)),
                      IN_W'(DIST_MIN + $urandom_range(0, 255)));
        end

        quiesce();
        program_gain(32'd1);
        idle_pct = 0;
        send_random(150);

        // Random gain, with the result side held off long enough to back up
        // the input.
        quiesce();
        program_gain($urandom());
        idle_pct = 40;
        hold_req <= 1'b1;
        send_random(300);

        quiesce();
        program_gain(GAIN_RESET);
        idle_pct = 0;
        send_random(200);
        quiesce();

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
